// File: hw/rtl/bsrs_pkg.sv
`default_nettype none
package bsrs_pkg;

   localparam int MATRIX_ROWS_DEF = 1024;
   localparam int BAND_SLOTS_DEF  = 16;

   localparam int ROW_IDX_W  = 10;
   localparam int COL_W      = 10;
   localparam int VALUE_W    = 64;
   localparam int RSP_FILL_W = 5;

   // One slot of a row: column tag and the stored double bits.
   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [VALUE_W-1:0] value;
   } slot_type;

   // Plus and minus zero both mean delete.
   function automatic logic is_zero(input logic [VALUE_W-1:0] v);
      return (v[VALUE_W-2:0] == '0);
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/bsrs_slot_mem.sv
`default_nettype none
module bsrs_slot_mem #(
   parameter int  DEPTH  = bsrs_pkg::MATRIX_ROWS_DEF * bsrs_pkg::BAND_SLOTS_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [ADDR_W-1:0]  wr_addr,
   input  wire bsrs_pkg::slot_type wr_data,
   input  wire logic [ADDR_W-1:0]  rd_addr,
   output bsrs_pkg::slot_type      rd_data
);

   bsrs_pkg::slot_type mem [DEPTH];
   bsrs_pkg::slot_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/bsrs_count_mem.sv
`default_nettype none
module bsrs_count_mem #(
   parameter int  DEPTH  = bsrs_pkg::MATRIX_ROWS_DEF,
   parameter int  DATA_W = $clog2(bsrs_pkg::BAND_SLOTS_DEF + 1),
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/banded_sparse_row_store.sv
// Sparse matrix store in row-wise ELLPACK form. Each of MATRIX_ROWS rows holds up to
// BAND_SLOTS (column, value) slots packed at the front, plus a fill count kept in a
// separate count memory. A write with a nonzero value overwrites the slot of a
// matching column or appends one; a write of plus or minus zero removes the matching
// slot and moves later slots down; a write of a new column to a full row is dropped
// with status 1. A read returns the stored value or zero, a found flag and the fill.
// After reset the block clears the fill counts row by row, with req_stall high. Items
// are handled one at a time: no request is accepted until the result of the last one
// has been registered. The column search is linear, through the single slot read port,
// and a delete of a present column then moves each later slot down one place. A row
// index at or beyond MATRIX_ROWS is answered with all fields zero.
`default_nettype none
module banded_sparse_row_store #(
   parameter int MATRIX_ROWS = bsrs_pkg::MATRIX_ROWS_DEF,
   parameter int BAND_SLOTS  = bsrs_pkg::BAND_SLOTS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic [bsrs_pkg::ROW_IDX_W-1:0]      req_row_index,
   input  wire logic [bsrs_pkg::COL_W-1:0]          req_col_index,
   input  wire logic [bsrs_pkg::VALUE_W-1:0]        req_entry_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [bsrs_pkg::VALUE_W-1:0]        rsp_read_value,
   output logic                                     rsp_found,
   output logic      [bsrs_pkg::RSP_FILL_W-1:0]     rsp_row_fill,
   output logic                                     rsp_status
);

   localparam int STORE_DEPTH = MATRIX_ROWS * BAND_SLOTS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int ROW_W       = $clog2(MATRIX_ROWS);
   localparam int FILL_W      = $clog2(BAND_SLOTS + 1);

   localparam logic [ADDR_W-1:0] BAND_A   = ADDR_W'(BAND_SLOTS);
   localparam logic [FILL_W-1:0] BAND_F   = FILL_W'(BAND_SLOTS);
   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(MATRIX_ROWS - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_COUNT  = 3'd2;
   localparam logic [2:0] ST_SEARCH = 3'd3;
   localparam logic [2:0] ST_ACT    = 3'd4;
   localparam logic [2:0] ST_SHIFT  = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   logic [2:0]                        state_ff, state_in;
   logic [ROW_W-1:0]                  clr_ff, clr_in;
   logic                              is_read_ff, is_read_in;
   logic                              in_range_ff, in_range_in;
   logic [ROW_W-1:0]                  row_ff, row_in;
   logic [bsrs_pkg::COL_W-1:0]        col_ff, col_in;
   logic [bsrs_pkg::VALUE_W-1:0]      val_ff, val_in;
   logic [ADDR_W-1:0]                 base_ff, base_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic [FILL_W-1:0]                 k_ff, k_in;
   logic                              pend_ff, pend_in;
   logic                              found_ff, found_in;
   logic [FILL_W-1:0]                 pos_ff, pos_in;
   logic [bsrs_pkg::VALUE_W-1:0]      hit_val_ff, hit_val_in;
   logic                              status_ff, status_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bsrs_pkg::VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic [bsrs_pkg::RSP_FILL_W-1:0]   rsp_fill_ff, rsp_fill_in;
   logic                              rsp_status_ff, rsp_status_in;

   logic                              slot_wr_en;
   logic [ADDR_W-1:0]                 slot_wr_addr;
   bsrs_pkg::slot_type                slot_wr_data;
   logic [ADDR_W-1:0]                 slot_rd_addr;
   bsrs_pkg::slot_type                slot_rd_data;

   logic                              cnt_wr_en;
   logic [ROW_W-1:0]                  cnt_wr_addr;
   logic [FILL_W-1:0]                 cnt_wr_data;
   logic [FILL_W-1:0]                 cnt_rd_data;

   logic                              accept;
   logic                              rsp_free;
   logic                              hit;

   bsrs_slot_mem #(
      .DEPTH (STORE_DEPTH)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   bsrs_count_mem #(
      .DEPTH  (MATRIX_ROWS),
      .DATA_W (FILL_W)
   ) u_count_mem (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (ROW_W'(req_row_index)),
      .rd_data (cnt_rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign hit       = pend_ff && (slot_rd_data.col == col_ff);

   assign slot_rd_addr = base_ff + ADDR_W'(k_ff);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      is_read_in    = is_read_ff;
      in_range_in   = in_range_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      val_in        = val_ff;
      base_in       = base_ff;
      fill_in       = fill_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      hit_val_in    = hit_val_ff;
      status_in     = status_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_status_in = rsp_status_ff;

      slot_wr_en    = 1'b0;
      slot_wr_addr  = base_ff + ADDR_W'(pos_ff);
      slot_wr_data  = '{col: col_ff, value: val_ff};

      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = row_ff;
      cnt_wr_data   = fill_ff;

      case (state_ff)
         ST_CLEAR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = clr_ff;
            cnt_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               is_read_in  = req_type;
               in_range_in = (32'(req_row_index) < MATRIX_ROWS);
               row_in      = ROW_W'(req_row_index);
               col_in      = req_col_index;
               val_in      = req_entry_value;
               base_in     = ADDR_W'(req_row_index) * BAND_A;
               found_in    = 1'b0;
               status_in   = 1'b0;
               hit_val_in  = '0;
               k_in        = '0;
               pend_in     = 1'b0;
               state_in    = ST_COUNT;
            end
         end
         ST_COUNT: begin
            // Count memory data for the row is valid now.
            if (!in_range_ff) begin
               fill_in  = '0;
               state_in = ST_RESP;
            end else begin
               fill_in  = (cnt_rd_data > BAND_F) ? BAND_F : cnt_rd_data;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Issue one slot read a cycle, compare the slot read the cycle before.
            if (hit) begin
               found_in   = 1'b1;
               pos_in     = k_ff - 1'b1;
               hit_val_in = slot_rd_data.value;
               pend_in    = 1'b0;
               state_in   = ST_ACT;
            end else if (k_ff < fill_ff) begin
               k_in    = k_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            state_in = ST_RESP;
            if (is_read_ff) begin
               // Nothing to change.
            end else if (bsrs_pkg::is_zero(val_ff)) begin
               if (found_ff) begin
                  k_in     = pos_ff + 1'b1;
                  pend_in  = 1'b0;
                  state_in = ST_SHIFT;
               end
            end else if (found_ff) begin
               slot_wr_en = 1'b1;
            end else if (fill_ff < BAND_F) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = base_ff + ADDR_W'(fill_ff);
               fill_in      = fill_ff + 1'b1;
            end else begin
               status_in = 1'b1;
            end
         end
         ST_SHIFT: begin
            // Slot k-1 arrives now; move it down to k-2.
            if (pend_ff) begin
               slot_wr_en   = 1'b1;
               slot_wr_addr = base_ff + ADDR_W'(k_ff - FILL_W'(2));
               slot_wr_data = slot_rd_data;
            end
            if (k_ff < fill_ff) begin
               k_in    = k_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               fill_in  = fill_ff - 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               cnt_wr_en     = in_range_ff;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = (is_read_ff && found_ff) ? hit_val_ff : '0;
               rsp_found_in  = found_ff;
               rsp_fill_in   = bsrs_pkg::RSP_FILL_W'(fill_ff);
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_read_ff    <= is_read_in;
      in_range_ff   <= in_range_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      val_ff        <= val_in;
      base_ff       <= base_in;
      fill_ff       <= fill_in;
      k_ff          <= k_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      hit_val_ff    <= hit_val_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_row_fill   = rsp_fill_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

   localparam int ROWS       = bsrs_pkg::MATRIX_ROWS_DEF;
   localparam int BAND       = bsrs_pkg::BAND_SLOTS_DEF;
   localparam int ROW_IDX_W  = bsrs_pkg::ROW_IDX_W;
   localparam int COL_W      = bsrs_pkg::COL_W;
   localparam int VALUE_W    = bsrs_pkg::VALUE_W;
   localparam int RSP_FILL_W = bsrs_pkg::RSP_FILL_W;

   localparam logic REQ_WRITE       = 1'b0;
   localparam logic REQ_READ        = 1'b1;
   localparam logic STATUS_ROW_FULL = 1'b1;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 64;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOT_ROWS        = 8;
   localparam int HOT_COLS        = 24;

   localparam logic [VALUE_W-1:0] PLUS_ZERO  = '0;
   localparam logic [VALUE_W-1:0] MINUS_ZERO = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] QUIET_NAN  = 64'h7FF8_0000_0000_0000;
   localparam logic [VALUE_W-1:0] MINUS_INF  = 64'hFFF0_0000_0000_0000;
   localparam logic [VALUE_W-1:0] NEG_TINY   = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};

   typedef struct packed {
      logic [VALUE_W-1:0]    read_value;
      logic                  found;
      logic [RSP_FILL_W-1:0] row_fill;
      logic                  status;
   } row_result_type;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_stall;
   logic                  req_type        = REQ_WRITE;
   logic [ROW_IDX_W-1:0]  req_row_index   = '0;
   logic [COL_W-1:0]      req_col_index   = '0;
   logic [VALUE_W-1:0]    req_entry_value = '0;
   logic                  rsp_valid;
   logic                  rsp_stall       = 1'b0;
   logic [VALUE_W-1:0]    rsp_read_value;
   logic                  rsp_found;
   logic [RSP_FILL_W-1:0] rsp_row_fill;
   logic                  rsp_status;

   // Shadow copy of the matrix: slots packed at the front of each row.
   logic [VALUE_W-1:0] shadow_value [ROWS][BAND];
   logic [COL_W-1:0]   shadow_col   [ROWS][BAND];
   int                 shadow_fill  [ROWS];

   row_result_type       expected_results[$];
   logic [ROW_IDX_W-1:0] hot_rows [HOT_ROWS];
   logic [COL_W-1:0]     hot_cols [HOT_COLS];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int cycle_count   = 0;
   int mismatches    = 0;
   int n_reads       = 0;
   int n_writes      = 0;
   int n_deletes     = 0;
   int n_results     = 0;
   int n_hits        = 0;
   int n_drops       = 0;

   banded_sparse_row_store #(
      .MATRIX_ROWS(ROWS),
      .BAND_SLOTS (BAND)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_row_index  (req_row_index),
      .req_col_index  (req_col_index),
      .req_entry_value(req_entry_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_found      (rsp_found),
      .rsp_row_fill   (rsp_row_fill),
      .rsp_status     (rsp_status)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d results outstanding",
                cycle_count, expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Apply one transaction to the shadow matrix and return the result it should give.
   function automatic row_result_type apply_row_update(input logic kind,
                                                       input logic [ROW_IDX_W-1:0] row,
                                                       input logic [COL_W-1:0] col,
                                                       input logic [VALUE_W-1:0] value);
      row_result_type res;
      int fill;
      int hit;
      int m;
      res = '0;
      if (row >= ROWS) return res;
      fill = shadow_fill[row];
      hit = fill;
      for (m = fill - 1; m >= 0; m--)
         if (shadow_col[row][m] == col) hit = m;
      res.found = (hit < fill);
      if (kind == REQ_READ) begin
         if (res.found) res.read_value = shadow_value[row][hit];
      end else if (value[VALUE_W-2:0] == '0) begin
         if (res.found) begin
            for (m = hit + 1; m < fill; m++) begin
               shadow_value[row][m-1] = shadow_value[row][m];
               shadow_col[row][m-1]   = shadow_col[row][m];
            end
            fill--;
         end
      end else if (res.found) begin
         shadow_value[row][hit] = value;
      end else if (fill < BAND) begin
         shadow_value[row][fill] = value;
         shadow_col[row][fill]   = col;
         fill++;
      end else begin
         res.status = STATUS_ROW_FULL;
      end
      shadow_fill[row] = fill;
      res.row_fill = RSP_FILL_W'(fill);
      return res;
   endfunction

   task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
                              input logic [VALUE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   // Predict on each accepted request, then compare each accepted result in order.
   always @(posedge clock) begin
      row_result_type want;
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) begin
            expected_results.push_back(apply_row_update(req_type, req_row_index,
                                                        req_col_index, req_entry_value));
            if (req_type == REQ_READ) n_reads++;
            else if (req_entry_value[VALUE_W-2:0] == '0) n_deletes++;
            else n_writes++;
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with no request outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               n_results++;
               if (want.found) n_hits++;
               if (want.status == STATUS_ROW_FULL) n_drops++;
               check_field("read_value", want.read_value, rsp_read_value);
               check_field("found", want.found, rsp_found);
               check_field("row_fill", want.row_fill, rsp_row_fill);
               check_field("status", want.status, rsp_status);
            end
         end
      end
   end

   // Result side: random stall, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
      end
   end

   // Called at a rising edge; returns at the edge where the transaction is taken.
   task automatic send_request(input logic kind, input logic [ROW_IDX_W-1:0] row,
                               input logic [COL_W-1:0] col,
                               input logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_row_index   <= row;
      req_col_index   <= col;
      req_entry_value <= value;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] random_nonzero_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(7))
         0: v = QUIET_NAN;
         1: v = MINUS_INF;
         2: v = NEG_TINY;
         3: v = '1;
         default: v = {$urandom, $urandom};
      endcase
      // Keep it a real write: any magnitude bit set.
      if (v[VALUE_W-2:0] == '0) v[0] = 1'b1;
      return v;
   endfunction

   function automatic logic [VALUE_W-1:0] random_zero_value();
      return $urandom_range(1) ? MINUS_ZERO : PLUS_ZERO;
   endfunction

   task automatic pick_hot_sets();
      int i;
      hot_rows[0] = '0;
      hot_rows[1] = '1;
      for (i = 2; i < HOT_ROWS; i++) hot_rows[i] = ROW_IDX_W'($urandom);
      hot_cols[0] = '0;
      hot_cols[1] = '1;
      for (i = 2; i < HOT_COLS; i++) hot_cols[i] = COL_W'($urandom);
   endtask

   // Mostly traffic on a few rows and columns so rows fill, overflow and shift.
   task automatic send_random_item();
      logic                 kind;
      logic [ROW_IDX_W-1:0] row;
      logic [COL_W-1:0]     col;
      logic [VALUE_W-1:0]   value;
      int                   roll;
      roll = $urandom_range(99);
      if (roll < 15) begin
         kind  = 1'($urandom);
         row   = ROW_IDX_W'($urandom);
         col   = COL_W'($urandom);
         value = {$urandom, $urandom};
      end else begin
         row  = hot_rows[$urandom_range(HOT_ROWS-1)];
         col  = hot_cols[$urandom_range(HOT_COLS-1)];
         roll = $urandom_range(99);
         if (roll < 50) begin
            kind  = REQ_WRITE;
            value = random_nonzero_value();
         end else if (roll < 70) begin
            kind  = REQ_WRITE;
            value = random_zero_value();
         end else begin
            kind  = REQ_READ;
            value = {$urandom, $urandom};
         end
      end
      send_request(kind, row, col, value);
   endtask

   task automatic test_directed_corners();
      int i;
      send_idle_pct = 7;
      rcv_idle_pct  = 47;
      // Fill the top row to the band limit, highest column first.
      for (i = 0; i < BAND; i++)
         send_request(REQ_WRITE, '1, (i == 0) ? '1 : COL_W'(i * 61), random_nonzero_value());
      send_request(REQ_WRITE, '1, COL_W'(500), random_nonzero_value());
      send_request(REQ_WRITE, '1, '0, QUIET_NAN);
      send_request(REQ_READ, '1, '0, '0);
      send_request(REQ_READ, '1, COL_W'(500), '1);
      send_request(REQ_WRITE, '1, '1, MINUS_ZERO);
      send_request(REQ_WRITE, '1, '1, PLUS_ZERO);
      send_request(REQ_WRITE, '1, COL_W'(500), '1);
      send_request(REQ_READ, '1, COL_W'(500), '0);
      send_request(REQ_READ, '0, '0, '0);
      send_request(REQ_WRITE, '0, '1, NEG_TINY);
      send_request(REQ_READ, '0, '1, '0);
   endtask

   task automatic test_random_traffic(input int count, input int sender_pct,
                                      input int receiver_pct);
      send_idle_pct = sender_pct;
      rcv_idle_pct  = receiver_pct;
      pick_hot_sets();
      repeat (count) send_random_item();
   endtask

   // Hold the result side off while requests keep coming, so the input backs up.
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      hold_request  = HOLD_OFF_CYCLES;
      repeat (40) send_random_item();
   endtask

   initial begin
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed_corners();
      test_random_traffic(300, 7, 47);
      test_random_traffic(300, 47, 7);
      test_output_hold_off();
      test_random_traffic(260, 0, 0);
      req_valid <= 1'b0;
      waited = 0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         mismatches++;
      end
      $display("Covered %0d writes, %0d deletes and %0d reads; %0d results checked",
               n_writes, n_deletes, n_reads, n_results);
      $display("  of which %0d found the column and %0d hit a full row", n_hits, n_drops);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
